// File: hw/rtl/smv_pkg.sv
`default_nettype none
package smv_pkg;

  localparam int unsigned VALUE_BUFFER_BYTES = 20;
  localparam int unsigned VBW = $clog2(VALUE_BUFFER_BYTES);
  localparam int unsigned HDR_BYTES = 20;
  localparam int unsigned TID_BYTES = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] STUN_COOKIE = 32'h2112A442;
  localparam logic [31:0] FP_XOR = 32'h5354554E;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  localparam logic [15:0] T_MAPPED = 16'h0001;
  localparam logic [15:0] T_INTEGRITY = 16'h0008;
  localparam logic [15:0] T_ERRCODE = 16'h0009;
  localparam logic [15:0] T_UNKNOWN = 16'h000A;
  localparam logic [15:0] T_XORMAPPED = 16'h0020;
  localparam logic [15:0] T_ALTSERVER = 16'h8023;
  localparam logic [15:0] T_FINGERPRINT = 16'h8028;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SHORT = 4'd1;
  localparam logic [3:0] ST_TYPE_BITS = 4'd2;
  localparam logic [3:0] ST_LEN_ALIGN = 4'd3;
  localparam logic [3:0] ST_COOKIE = 4'd4;
  localparam logic [3:0] ST_TRUNCATED = 4'd5;
  localparam logic [3:0] ST_ATTR_HDR = 4'd6;
  localparam logic [3:0] ST_ATTR_OVERRUN = 4'd7;
  localparam logic [3:0] ST_ADDRESS = 4'd8;
  localparam logic [3:0] ST_ERROR_CODE = 4'd9;
  localparam logic [3:0] ST_ODD_LIST = 4'd10;
  localparam logic [3:0] ST_INTEG_LEN = 4'd11;
  localparam logic [3:0] ST_FP_LEN = 4'd12;
  localparam logic [3:0] ST_FP_MISMATCH = 4'd13;
  localparam logic [3:0] ST_FP_NOT_LAST = 4'd14;

  localparam logic KIND_ATTR = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic        record_kind;
    logic [1:0]  msg_class;
    logic [11:0] msg_method;
    logic [15:0] attr_type;
    logic [15:0] attr_len;
    logic [15:0] attr_offset;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [9:0]  error_code;
    logic [3:0]  status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        has_rec;
    out_t        rec;
    logic        has_vrd;
    logic [3:0]  vrd_status;
    logic [1:0]  msg_class;
    logic [11:0] msg_method;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/smv_queue.sv
`default_nettype none
module smv_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire smv_pkg::job_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output smv_pkg::job_t      data_o
);

  localparam int unsigned PW = $clog2(smv_pkg::QUEUE_DEPTH);

  smv_pkg::job_t mem_q [smv_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0] cnt_q;

  assign full_o = (cnt_q == (PW+1)'(smv_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/smv_front.sv
`default_nettype none
module smv_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire smv_pkg::in_t  in_data_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output smv_pkg::job_t      job_o
);

  localparam int unsigned VB = smv_pkg::VALUE_BUFFER_BYTES;
  localparam int unsigned VBW = smv_pkg::VBW;

  logic [16:0] pos_q;
  logic [13:0] mtype_q, mtype_d;
  logic [15:0] mlen_q, mlen_d;
  logic [7:0]  tid_q [smv_pkg::TID_BYTES];
  logic [7:0]  tid_d [smv_pkg::TID_BYTES];
  logic [15:0] atype_q, atype_d, alen_q, alen_d, astart_q, astart_d;
  logic [7:0]  vbuf_q [VB];
  logic [7:0]  vbuf_d [VB];
  logic [31:0] crc_q, crc_start_q, crc_start_d;
  logic [3:0]  err_q, err_d;

  logic        acc;
  logic [7:0]  b;
  logic [3:0]  hdr_e, attr_e;
  logic        done;
  logic [16:0] a, o, vi;
  logic [17:0] pad_end;
  logic [15:0] alen_cur;
  logic [3:0]  tid_idx;
  logic [7:0]  cookie_byte;

  assign acc = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign b = in_data_i.data_byte;
  assign tid_idx = 4'(pos_q[4:0] - 5'd8);
  assign cookie_byte = 8'(smv_pkg::STUN_COOKIE >> {(2'd3 - pos_q[1:0]), 3'b000});

  // Parse one byte: header fields, then the attribute walk.
  always_comb begin
    mtype_d = mtype_q;
    mlen_d = mlen_q;
    tid_d = tid_q;
    atype_d = atype_q;
    alen_d = alen_q;
    astart_d = astart_q;
    vbuf_d = vbuf_q;
    crc_start_d = crc_start_q;
    hdr_e = smv_pkg::ST_OK;
    attr_e = smv_pkg::ST_OK;
    done = 1'b0;
    a = pos_q - 17'(smv_pkg::HDR_BYTES);
    o = a - {1'b0, astart_q};
    pad_end = 18'd4 + (({2'b00, alen_q} + 18'd3) & ~18'd3);
    alen_cur = alen_q;
    vi = '0;
    if (acc) begin
      if (pos_q < 17'(smv_pkg::HDR_BYTES)) begin
        if (pos_q == 17'd0) begin
          mtype_d = {b[5:0], mtype_q[7:0]};
          if ((b & 8'hC0) != 8'd0) hdr_e = smv_pkg::ST_TYPE_BITS;
        end else if (pos_q == 17'd1) begin
          mtype_d = {mtype_q[13:8], b};
        end else if (pos_q == 17'd2) begin
          mlen_d = {b, mlen_q[7:0]};
        end else if (pos_q == 17'd3) begin
          mlen_d = {mlen_q[15:8], b};
          if (b[1:0] != 2'b00) hdr_e = smv_pkg::ST_LEN_ALIGN;
        end else if (pos_q < 17'd8) begin
          if (b != cookie_byte) hdr_e = smv_pkg::ST_COOKIE;
        end else begin
          tid_d[tid_idx] = b;
        end
      end else if (err_q == smv_pkg::ST_OK && a < {1'b0, mlen_q}) begin
        if (a == 17'd0 || (o >= 17'd4 && {1'b0, o} == pad_end)) begin
          if ({1'b0, a} + 18'd4 > {2'b00, mlen_q}) begin
            attr_e = smv_pkg::ST_ATTR_HDR;
          end else begin
            astart_d = a[15:0];
            atype_d = '0;
            alen_d = '0;
            alen_cur = '0;
            crc_start_d = crc_q;
            o = '0;
          end
        end
        if (attr_e == smv_pkg::ST_OK) begin
          vi = o - 17'd4;
          if (o == 17'd0) begin
            atype_d = {b, 8'd0};
          end else if (o == 17'd1) begin
            atype_d = {atype_q[15:8], b};
          end else if (o == 17'd2) begin
            alen_d = {b, 8'd0};
          end else if (o == 17'd3) begin
            alen_d = {alen_q[15:8], b};
            if ({2'b00, astart_q} + 18'd4 + {2'b00, alen_d} > {2'b00, mlen_q}) begin
              attr_e = smv_pkg::ST_ATTR_OVERRUN;
            end else if (alen_d == 16'd0) begin
              done = 1'b1;
            end
          end else if (vi < {1'b0, alen_cur}) begin
            if (vi < 17'(VB)) vbuf_d[vi[VBW-1:0]] = b;
            if (vi + 17'd1 == {1'b0, alen_cur}) done = 1'b1;
          end
        end
      end
    end
  end

  // Check and decode the finished attribute.
  logic [3:0]  fin_st;
  logic [15:0] fin_port;
  logic [63:0] fin_hi, fin_lo;
  logic [9:0]  fin_ec;
  logic [7:0]  fam;
  logic [2:0]  ecls;
  logic [31:0] fp_val;
  logic        is_xor;

  always_comb begin
    fin_st = smv_pkg::ST_OK;
    fin_port = '0;
    fin_hi = '0;
    fin_lo = '0;
    fin_ec = '0;
    fam = (alen_d >= 16'd4) ? vbuf_d[1] : 8'd0;
    ecls = vbuf_d[2][2:0];
    fp_val = {vbuf_d[0], vbuf_d[1], vbuf_d[2], vbuf_d[3]};
    is_xor = (atype_d == smv_pkg::T_XORMAPPED);
    if (atype_d == smv_pkg::T_MAPPED || atype_d == smv_pkg::T_ALTSERVER || is_xor) begin
      if (fam == 8'd1 && alen_d == 16'd8) begin
        fin_port = {vbuf_d[2], vbuf_d[3]};
        fin_lo = {32'd0, vbuf_d[4], vbuf_d[5], vbuf_d[6], vbuf_d[7]};
        if (is_xor) begin
          fin_port = fin_port ^ smv_pkg::STUN_COOKIE[31:16];
          fin_lo = fin_lo ^ {32'd0, smv_pkg::STUN_COOKIE};
        end
      end else if (fam == 8'd2 && alen_d == 16'd20) begin
        fin_port = {vbuf_d[2], vbuf_d[3]};
        fin_hi = {vbuf_d[4], vbuf_d[5], vbuf_d[6], vbuf_d[7],
                  vbuf_d[8], vbuf_d[9], vbuf_d[10], vbuf_d[11]};
        fin_lo = {vbuf_d[12], vbuf_d[13], vbuf_d[14], vbuf_d[15],
                  vbuf_d[16], vbuf_d[17], vbuf_d[18], vbuf_d[19]};
        if (is_xor) begin
          fin_port = fin_port ^ smv_pkg::STUN_COOKIE[31:16];
          fin_hi = fin_hi ^ {smv_pkg::STUN_COOKIE, tid_d[0], tid_d[1], tid_d[2], tid_d[3]};
          fin_lo = fin_lo ^ {tid_d[4], tid_d[5], tid_d[6], tid_d[7],
                             tid_d[8], tid_d[9], tid_d[10], tid_d[11]};
        end
      end else begin
        fin_st = smv_pkg::ST_ADDRESS;
      end
    end else if (atype_d == smv_pkg::T_ERRCODE) begin
      if (alen_d < 16'd4) begin
        fin_st = smv_pkg::ST_ERROR_CODE;
      end else if (vbuf_d[3] >= 8'd100 || ecls < 3'd3 || ecls > 3'd6) begin
        fin_st = smv_pkg::ST_ERROR_CODE;
      end else begin
        fin_ec = (10'(ecls) * 10'd100) + {2'b00, vbuf_d[3]};
      end
    end else if (atype_d == smv_pkg::T_UNKNOWN) begin
      if (alen_d[0]) fin_st = smv_pkg::ST_ODD_LIST;
    end else if (atype_d == smv_pkg::T_INTEGRITY) begin
      if (alen_d != 16'd20) fin_st = smv_pkg::ST_INTEG_LEN;
    end else if (atype_d == smv_pkg::T_FINGERPRINT) begin
      if (alen_d != 16'd4) begin
        fin_st = smv_pkg::ST_FP_LEN;
      end else if (fp_val != (~crc_start_d ^ smv_pkg::FP_XOR)) begin
        fin_st = smv_pkg::ST_FP_MISMATCH;
      end else if ({1'b0, astart_d} + 17'd8 < {1'b0, mlen_d}) begin
        fin_st = smv_pkg::ST_FP_NOT_LAST;
      end
    end
  end

  // Error tracking, verdict and the job for the back end.
  logic [17:0] count;
  logic [3:0]  vrd;
  logic [1:0]  mclass;
  logic [11:0] mmethod;

  assign mclass = {mtype_d[8], mtype_d[4]};
  assign mmethod = {mtype_d[13:9], mtype_d[7:5], mtype_d[3:0]};
  assign count = {1'b0, pos_q} + 18'd1;

  always_comb begin
    err_d = err_q;
    if (hdr_e != smv_pkg::ST_OK && err_q == smv_pkg::ST_OK) err_d = hdr_e;
    if (attr_e != smv_pkg::ST_OK) err_d = attr_e;
    if (done && fin_st != smv_pkg::ST_OK) err_d = fin_st;
    if (count < 18'(smv_pkg::HDR_BYTES)) begin
      vrd = smv_pkg::ST_SHORT;
    end else if (err_d == smv_pkg::ST_TYPE_BITS || err_d == smv_pkg::ST_LEN_ALIGN ||
                 err_d == smv_pkg::ST_COOKIE) begin
      vrd = err_d;
    end else if (mlen_d == 16'd0) begin
      vrd = smv_pkg::ST_OK;
    end else if (count < 18'(smv_pkg::HDR_BYTES) + {2'b00, mlen_d}) begin
      vrd = smv_pkg::ST_TRUNCATED;
    end else begin
      vrd = err_d;
    end
    job_o.has_rec = done;
    job_o.has_vrd = in_data_i.end_of_packet;
    job_o.vrd_status = vrd;
    job_o.msg_class = mclass;
    job_o.msg_method = mmethod;
    job_o.rec.record_kind = smv_pkg::KIND_ATTR;
    job_o.rec.msg_class = mclass;
    job_o.rec.msg_method = mmethod;
    job_o.rec.attr_type = atype_d;
    job_o.rec.attr_len = alen_d;
    job_o.rec.attr_offset = astart_d + 16'(smv_pkg::HDR_BYTES);
    job_o.rec.port = fin_port;
    job_o.rec.addr_high = fin_hi;
    job_o.rec.addr_low = fin_lo;
    job_o.rec.error_code = fin_ec;
    job_o.rec.status = fin_st;
    job_o.rec.last = !in_data_i.end_of_packet;
    push_o = acc && (done || in_data_i.end_of_packet);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      mtype_q <= '0;
      mlen_q <= '0;
      atype_q <= '0;
      alen_q <= '0;
      astart_q <= '0;
      crc_q <= '1;
      crc_start_q <= '0;
      err_q <= smv_pkg::ST_OK;
    end else if (acc) begin
      if (in_data_i.end_of_packet) begin
        pos_q <= '0;
        mtype_q <= '0;
        mlen_q <= '0;
        atype_q <= '0;
        alen_q <= '0;
        astart_q <= '0;
        crc_q <= '1;
        crc_start_q <= '0;
        err_q <= smv_pkg::ST_OK;
      end else begin
        if (pos_q != smv_pkg::POS_MAX) pos_q <= pos_q + 17'd1;
        mtype_q <= mtype_d;
        mlen_q <= mlen_d;
        atype_q <= atype_d;
        alen_q <= alen_d;
        astart_q <= astart_d;
        crc_q <= smv_pkg::crc_byte(crc_q, b);
        crc_start_q <= crc_start_d;
        err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q <= tid_d;
    vbuf_q <= vbuf_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/smv_back.sv
`default_nettype none
module smv_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire smv_pkg::job_t q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output smv_pkg::out_t      out_data_o
);

  logic          out_valid_q;
  smv_pkg::out_t out_q;
  logic          pend_q;
  logic [3:0]    pend_st_q;
  logic [1:0]    pend_cls_q;
  logic [11:0]   pend_mth_q;
  logic          free;
  smv_pkg::out_t vrd;

  assign free = !out_valid_q || !out_stall_i;
  assign pop_o = free && !pend_q && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    vrd = '0;
    vrd.record_kind = smv_pkg::KIND_VERDICT;
    vrd.last = 1'b1;
    if (pend_q) begin
      vrd.msg_class = pend_cls_q;
      vrd.msg_method = pend_mth_q;
      vrd.status = pend_st_q;
    end else begin
      vrd.msg_class = q_data_i.msg_class;
      vrd.msg_method = q_data_i.msg_method;
      vrd.status = q_data_i.vrd_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q <= 1'b0;
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        pend_q <= q_data_i.has_rec && q_data_i.has_vrd;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (pend_q) begin
        out_q <= vrd;
      end else if (q_valid_i) begin
        out_q <= q_data_i.has_rec ? q_data_i.rec : vrd;
        pend_st_q <= q_data_i.vrd_status;
        pend_cls_q <= q_data_i.msg_class;
        pend_mth_q <= q_data_i.msg_method;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/stun_message_validator_unit.sv
// Channel | handshake               | payload
// input   | in_valid_i / in_stall_o   | in_data_i  (smv_pkg::in_t, one packet byte)
// output  | out_valid_o / out_stall_i | out_data_o (smv_pkg::out_t, record or verdict)
//
// The front end takes one byte per clock unless the queue is full and parses it in
// that cycle. A byte yields up to two results, which the back end sends one per cycle
// unless the output stalls: an attribute's record first, then the packet's verdict.
// A two-entry queue separates the two; the input stalls only when it is full.
// Async active-low reset empties the queue, clears the parser but TID/value buffers.
`default_nettype none
module stun_message_validator_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire smv_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output smv_pkg::out_t      out_data_o
);

  // Jobs from the parser to the output sequencer.
  logic          push, full, pop, q_valid;
  smv_pkg::job_t push_job, q_job;

  smv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  smv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_job)
  );

  smv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/smv_checker.sv
`default_nettype none
module smv_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire smv_pkg::out_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind |-> out_data_o.last)
    else $error("verdict without last");

  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind |->
      out_data_o.attr_type == 16'd0 && out_data_o.attr_len == 16'd0 &&
      out_data_o.port == 16'd0 && out_data_o.error_code == 10'd0)
    else $error("verdict carries attribute data");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid in reset");

endmodule

bind stun_message_validator_unit smv_checker u_smv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
